// ----- hdl/prefix_code_tree_decoder_macros.svh -----
// Assertion macros shared by the checker files of the prefix-code tree decoder.
// Each macro states one concurrent property, disabled while reset is low.
`ifndef PREFIX_CODE_TREE_DECODER_MACROS_SVH
`define PREFIX_CODE_TREE_DECODER_MACROS_SVH

// Overlapping implication: the consequent must hold in the cycle of the antecedent.
`define PCTD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("prefix code tree decoder: assertion failed");

// Non-overlapping implication: the consequent must hold in the cycle after the antecedent.
`define PCTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("prefix code tree decoder: assertion failed");

`endif

// ----- hdl/pctd_pkg.sv -----
// ----------------------------------------------------------------------------
// Prefix-code tree decoder package
// Sizes, transaction types, operation codes and controller states.
// ----------------------------------------------------------------------------
package pctd_pkg;

	localparam int INTERNAL_NODES = 128;
	localparam int SYMBOL_BITS    = 7;
	localparam int BITS_PER_BYTE  = 8;
	localparam int MAX_BITS       = (BITS_PER_BYTE < 8) ? BITS_PER_BYTE : 8;

	localparam int NODE_W   = (INTERNAL_NODES > 1) ? $clog2(INTERNAL_NODES) : 1;
	localparam int CHILD_W  = NODE_W + 1;
	localparam int CHILDREN = 2 * INTERNAL_NODES;
	localparam int VAL_W    = (NODE_W > SYMBOL_BITS) ? NODE_W : SYMBOL_BITS;
	localparam int USED_W   = $clog2(INTERNAL_NODES + 1);
	localparam int DEPTH_W  = 7;
	localparam int SUM_W    = ((USED_W > DEPTH_W) ? USED_W : DEPTH_W) + 1;
	localparam int CNT_W    = 4;
	localparam int RES_SYM_W = 7;

	typedef logic [NODE_W-1:0]    node_t;
	typedef logic [CHILD_W-1:0]   child_idx_t;
	typedef logic [VAL_W-1:0]     val_t;
	typedef logic [USED_W-1:0]    used_t;
	typedef logic [DEPTH_W-1:0]   depth_t;
	typedef logic [SUM_W-1:0]     sum_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [RES_SYM_W-1:0] sym_res_t;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_DATA  = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0] op;
		logic [6:0] symbol;
		logic [6:0] code_length;
		logic [7:0] data_byte;
		logic [3:0] bit_count;
	} item_t;

	typedef struct packed {
		logic [6:0] symbol_res;
		logic       last;
		logic       bad_code;
	} result_t;

	// One child link; the present flag lives in flip-flops in the node store.
	typedef struct packed {
		logic leaf;
		val_t val;
	} link_t;

	typedef struct packed {
		logic       clear;
		child_idx_t ch_rd_addr;
		logic       ch_wr;
		child_idx_t ch_wr_addr;
		link_t      ch_wr_data;
		node_t      par_rd_addr;
		logic       par_wr;
		node_t      par_wr_addr;
		node_t      par_wr_data;
		node_t      probe_node;
	} store_cmd_t;

	typedef struct packed {
		logic       ch_rd_present;
		link_t      ch_rd_data;
		node_t      par_rd_data;
		logic [1:0] probe_present;
	} store_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLIMB,
		ST_CLIMB_WAIT,
		ST_ALLOC,
		ST_DESCEND,
		ST_ATTACH,
		ST_DEC_ISSUE,
		ST_DEC_STEP,
		ST_FLUSH
	} state_t;

endpackage

// ----- hdl/prefix_code_tree_decoder.sv -----
// ----------------------------------------------------------------------------
// Prefix-code tree decoder
// Builds a binary code tree from (symbol, code length) entries and decodes
// packed bit streams against it, least-significant bit first.
// ----------------------------------------------------------------------------
// Usage:
// A transaction is accepted on a rising edge where start is high and busy is
// low; item carries op, symbol, code_length, data_byte and bit_count.
// A clear transaction returns the tree to its reset state.
// A load transaction climbs past full nodes, creates the internal nodes
// still needed and attaches the leaf; the node store has one parent-memory
// read port, so each climb step issues the parent read and then waits for it.
// A data transaction walks one bit per cycle through the child-link memory
// (bit_count clamped to 8), then the final result leaves the output
// register. A zero bit_count is done with no result.
// Each leaf or missing child produces one result transaction, shown on result
// for exactly one cycle with result_valid high; the last one of a data byte
// has last set. The receiver cannot stall, so results are never held.
// busy stays high until the last result has been presented.
// After reset the tree is empty, every child absent, and the decode walk sits
// at the root; the walk position survives between data bytes and loads.
// ----------------------------------------------------------------------------
module prefix_code_tree_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pctd_pkg::item_t   item,
	output logic              busy,
	output logic              result_valid,
	output pctd_pkg::result_t result
);

	pctd_pkg::state_t     state_q, state_nx;
	pctd_pkg::store_cmd_t cmd;
	pctd_pkg::store_rsp_t rsp;

	// Tree builder and walk state.
	pctd_pkg::node_t  build_node_q;
	pctd_pkg::depth_t build_depth_q;
	pctd_pkg::used_t  nodes_used_q;
	pctd_pkg::node_t  walk_q;

	// Working registers for the transaction in progress.
	logic [6:0]       sym_q;
	logic [6:0]       len_q;
	logic [7:0]       byte_q;
	pctd_pkg::cnt_t   cnt_q;
	pctd_pkg::node_t  node_q;
	pctd_pkg::depth_t depth_q;
	pctd_pkg::depth_t need_q;

	// A decoded result is held back until the next one or the flush so the last one can be flagged.
	logic                 pend_valid_q;
	pctd_pkg::sym_res_t   pend_sym_q;
	logic                 pend_bad_q;

	logic                 result_valid_q;
	pctd_pkg::result_t    result_q;

	logic                 accept;
	pctd_pkg::cnt_t       bits_in;
	logic                 side;
	logic                 full;
	logic                 deeper;
	pctd_pkg::depth_t     need_w;
	pctd_pkg::sum_t       need_sum;
	logic                 fits;
	logic                 absent;
	logic                 hit_leaf;
	logic                 res_now;
	pctd_pkg::node_t      walk_nx;
	logic                 emit;
	pctd_pkg::result_t    emit_data;

	pctd_node_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	assign accept  = start && !busy;
	assign bits_in = (item.bit_count > pctd_pkg::cnt_t'(pctd_pkg::MAX_BITS)) ?
		pctd_pkg::cnt_t'(pctd_pkg::MAX_BITS) : item.bit_count;

	// Next free child goes left first; a full node has both children present.
	assign side = rsp.probe_present[0];
	assign full = rsp.probe_present[0] && rsp.probe_present[1];

	// Internal nodes still needed to reach depth code_length - 1.
	assign deeper   = {1'b0, len_q} > ({1'b0, depth_q} + 8'd1);
	assign need_w   = deeper ? (len_q - 7'd1 - depth_q) : '0;
	assign need_sum = pctd_pkg::sum_t'(nodes_used_q) + pctd_pkg::sum_t'(need_w);
	assign fits     = need_sum <= pctd_pkg::sum_t'(pctd_pkg::INTERNAL_NODES);

	// Decode step on the child link read in the previous cycle.
	assign absent   = !rsp.ch_rd_present;
	assign hit_leaf = rsp.ch_rd_present && rsp.ch_rd_data.leaf;
	assign res_now  = absent || hit_leaf;
	assign walk_nx  = res_now ? '0 : rsp.ch_rd_data.val[pctd_pkg::NODE_W-1:0];

	// Next-state logic.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			pctd_pkg::ST_IDLE: begin
				if (accept) begin
					if (item.op == pctd_pkg::OP_LOAD) begin
						state_nx = pctd_pkg::ST_CLIMB;
					end else if (item.op == pctd_pkg::OP_DATA && bits_in != '0) begin
						state_nx = pctd_pkg::ST_DEC_ISSUE;
					end
				end
			end
			pctd_pkg::ST_CLIMB: begin
				if (!full) begin
					state_nx = pctd_pkg::ST_ALLOC;
				end else if (node_q == '0) begin
					state_nx = pctd_pkg::ST_IDLE;
				end else begin
					state_nx = pctd_pkg::ST_CLIMB_WAIT;
				end
			end
			pctd_pkg::ST_CLIMB_WAIT: begin
				state_nx = pctd_pkg::ST_CLIMB;
			end
			pctd_pkg::ST_ALLOC: begin
				if (!fits) begin
					state_nx = pctd_pkg::ST_IDLE;
				end else if (need_w != '0) begin
					state_nx = pctd_pkg::ST_DESCEND;
				end else begin
					state_nx = pctd_pkg::ST_ATTACH;
				end
			end
			pctd_pkg::ST_DESCEND: begin
				if (need_q == pctd_pkg::depth_t'(1)) begin
					state_nx = pctd_pkg::ST_ATTACH;
				end
			end
			pctd_pkg::ST_ATTACH: begin
				state_nx = pctd_pkg::ST_IDLE;
			end
			pctd_pkg::ST_DEC_ISSUE: begin
				state_nx = pctd_pkg::ST_DEC_STEP;
			end
			pctd_pkg::ST_DEC_STEP: begin
				if (cnt_q == pctd_pkg::cnt_t'(1)) begin
					state_nx = pctd_pkg::ST_FLUSH;
				end
			end
			pctd_pkg::ST_FLUSH: begin
				state_nx = pctd_pkg::ST_IDLE;
			end
			default: begin
				state_nx = pctd_pkg::ST_IDLE;
			end
		endcase
	end

	// Output logic: node store commands and result emission.
	always_comb begin
		cmd             = '0;
		cmd.probe_node  = node_q;
		cmd.par_rd_addr = node_q;
		cmd.ch_rd_addr  = {walk_q, byte_q[0]};
		emit            = 1'b0;
		emit_data       = '0;
		case (state_q)
			pctd_pkg::ST_IDLE: begin
				cmd.clear = accept && (item.op == pctd_pkg::OP_CLEAR);
			end
			pctd_pkg::ST_DESCEND: begin
				cmd.ch_wr           = 1'b1;
				cmd.ch_wr_addr      = {node_q, side};
				cmd.ch_wr_data.leaf = 1'b0;
				cmd.ch_wr_data.val  = pctd_pkg::val_t'(nodes_used_q);
				cmd.par_wr          = 1'b1;
				cmd.par_wr_addr     = nodes_used_q[pctd_pkg::NODE_W-1:0];
				cmd.par_wr_data     = node_q;
			end
			pctd_pkg::ST_ATTACH: begin
				cmd.ch_wr           = 1'b1;
				cmd.ch_wr_addr      = {node_q, side};
				cmd.ch_wr_data.leaf = 1'b1;
				cmd.ch_wr_data.val  = pctd_pkg::val_t'(sym_q[pctd_pkg::SYMBOL_BITS-1:0]);
			end
			pctd_pkg::ST_DEC_STEP: begin
				cmd.ch_rd_addr       = {walk_nx, byte_q[1]};
				emit                 = res_now && pend_valid_q;
				emit_data.symbol_res = pend_sym_q;
				emit_data.last       = 1'b0;
				emit_data.bad_code   = pend_bad_q;
			end
			pctd_pkg::ST_FLUSH: begin
				emit                 = pend_valid_q;
				emit_data.symbol_res = pend_sym_q;
				emit_data.last       = 1'b1;
				emit_data.bad_code   = pend_bad_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= pctd_pkg::ST_IDLE;
			build_node_q   <= '0;
			build_depth_q  <= '0;
			nodes_used_q   <= pctd_pkg::used_t'(1);
			walk_q         <= '0;
			pend_valid_q   <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_nx;
			result_valid_q <= emit;
			case (state_q)
				pctd_pkg::ST_IDLE: begin
					pend_valid_q <= 1'b0;
					if (accept && item.op == pctd_pkg::OP_CLEAR) begin
						build_node_q  <= '0;
						build_depth_q <= '0;
						nodes_used_q  <= pctd_pkg::used_t'(1);
						walk_q        <= '0;
					end
				end
				pctd_pkg::ST_DESCEND: begin
					nodes_used_q <= nodes_used_q + pctd_pkg::used_t'(1);
				end
				pctd_pkg::ST_ATTACH: begin
					build_node_q  <= node_q;
					build_depth_q <= depth_q;
				end
				pctd_pkg::ST_DEC_STEP: begin
					walk_q <= walk_nx;
					if (res_now) begin
						pend_valid_q <= 1'b1;
					end
				end
				pctd_pkg::ST_FLUSH: begin
					pend_valid_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Working payload registers need no reset.
	always_ff @(posedge clk) begin
		result_q <= emit_data;
		case (state_q)
			pctd_pkg::ST_IDLE: begin
				sym_q   <= item.symbol;
				len_q   <= item.code_length;
				byte_q  <= item.data_byte;
				cnt_q   <= bits_in;
				node_q  <= build_node_q;
				depth_q <= build_depth_q;
			end
			pctd_pkg::ST_CLIMB_WAIT: begin
				node_q  <= rsp.par_rd_data;
				depth_q <= depth_q - pctd_pkg::depth_t'(1);
			end
			pctd_pkg::ST_ALLOC: begin
				need_q <= need_w;
			end
			pctd_pkg::ST_DESCEND: begin
				node_q  <= nodes_used_q[pctd_pkg::NODE_W-1:0];
				depth_q <= depth_q + pctd_pkg::depth_t'(1);
				need_q  <= need_q - pctd_pkg::depth_t'(1);
			end
			pctd_pkg::ST_DEC_STEP: begin
				byte_q <= {1'b0, byte_q[7:1]};
				cnt_q  <= cnt_q - pctd_pkg::cnt_t'(1);
				if (res_now) begin
					pend_sym_q <= absent ? '0 : pctd_pkg::sym_res_t'(rsp.ch_rd_data.val);
					pend_bad_q <= absent;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != pctd_pkg::ST_IDLE) || result_valid_q;
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- hdl/pctd_node_store.sv -----
// ----------------------------------------------------------------------------
// Prefix-code tree node store
// Child-link memory, parent memory and per-child present flags.
// ----------------------------------------------------------------------------
module pctd_node_store (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pctd_pkg::store_cmd_t  cmd,
	output pctd_pkg::store_rsp_t  rsp
);

	logic [pctd_pkg::CHILDREN-1:0] present_q;
	pctd_pkg::link_t               child_mem [pctd_pkg::CHILDREN];
	pctd_pkg::node_t               parent_mem [pctd_pkg::INTERNAL_NODES];
	pctd_pkg::link_t               ch_rd_data_q;
	logic                          ch_rd_present_q;
	pctd_pkg::node_t               par_rd_data_q;

	// Present flags clear all at once, so the memories never need a sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else if (cmd.clear) begin
			present_q <= '0;
		end else if (cmd.ch_wr) begin
			present_q[cmd.ch_wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ch_wr) begin
			child_mem[cmd.ch_wr_addr] <= cmd.ch_wr_data;
		end
		ch_rd_data_q    <= child_mem[cmd.ch_rd_addr];
		ch_rd_present_q <= present_q[cmd.ch_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.par_wr) begin
			parent_mem[cmd.par_wr_addr] <= cmd.par_wr_data;
		end
		par_rd_data_q <= parent_mem[cmd.par_rd_addr];
	end

	always_comb begin
		rsp.ch_rd_present    = ch_rd_present_q;
		rsp.ch_rd_data       = ch_rd_data_q;
		rsp.par_rd_data      = par_rd_data_q;
		rsp.probe_present[0] = present_q[{cmd.probe_node, 1'b0}];
		rsp.probe_present[1] = present_q[{cmd.probe_node, 1'b1}];
	end

endmodule

// ----- hdl/pctd_checker.sv -----
// ----------------------------------------------------------------------------
// Prefix-code tree decoder port checker
// Watches the top-level ports and checks transaction ordering rules.
// ----------------------------------------------------------------------------
`include "prefix_code_tree_decoder_macros.svh"

module pctd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input pctd_pkg::item_t   item,
	input logic              busy,
	input logic              result_valid,
	input pctd_pkg::result_t result
);

	// Clear, load and unused operations never produce a result.
	`PCTD_ASSERT_NEXT(a_no_result_off_data, clk, arst_n, start && !busy && item.op != pctd_pkg::OP_DATA, !result_valid)
	// A data byte with valid bits keeps the block occupied.
	`PCTD_ASSERT_NEXT(a_data_goes_busy, clk, arst_n, start && !busy && item.op == pctd_pkg::OP_DATA && item.bit_count != 4'd0, busy)
	// A bad code carries symbol zero.
	`PCTD_ASSERT_SAME(a_bad_code_zero, clk, arst_n, result_valid && result.bad_code, result.symbol_res == 7'd0)
	// More results follow a result not marked last, so the block stays busy.
	`PCTD_ASSERT_NEXT(a_more_follow, clk, arst_n, result_valid && !result.last, busy)
	// Nothing follows the last result of a byte in the next cycle.
	`PCTD_ASSERT_NEXT(a_last_ends, clk, arst_n, result_valid && result.last, !result_valid)

endmodule

bind prefix_code_tree_decoder pctd_checker u_pctd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.item         (item),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

// ----- tb/prefix_code_tree_decoder_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Prefix-code tree decoder testbench
// Drives clear, load and data transactions into the decoder. A behavioral
// copy of the code tree predicts the decoded symbols and bad-code results
// not typed in the table; each result strobe is checked in queue order.
// ----------------------------------------------------------------------------
module prefix_code_tree_decoder_tb;

	// The package enum stops at the data opcode; the fourth encoding is unused.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int NODES      = pctd_pkg::INTERNAL_NODES;
	localparam int BYTE_BITS  = pctd_pkg::MAX_BITS;
	localparam int RAND_ITEMS = 340;
	// Marks a directed row whose results come from the tree predictor.
	localparam int FROM_TREE  = -1;

	logic              clk;
	logic              arst_n;
	logic              start;
	pctd_pkg::item_t   item;
	logic              busy;
	logic              result_valid;
	pctd_pkg::result_t result;

	prefix_code_tree_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.item        (item),
		.busy        (busy),
		.result_valid(result_valid),
		.result      (result)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// ------------------------------------------------------------------------
	// Behavioral code tree. Each internal node has two child links; a link is
	// either absent, a leaf carrying a symbol, or a pointer to another node.
	// ------------------------------------------------------------------------
	bit         kid_present [NODES][2];
	bit         kid_leaf    [NODES][2];
	logic [6:0] kid_val     [NODES][2];
	int         parent_of   [NODES];
	int         build_at;
	int         build_depth;
	int         nodes_alloc;
	int         walk_at;

	// Decoded results still owed by the decoder, oldest first.
	pctd_pkg::result_t owed_symbols[$];

	int         mismatches;
	int         results_seen;
	int         bad_seen;
	int         items_sent;
	int         loads_sent;
	int         bytes_sent;
	int         idle_pct;

	function automatic void tree_clear();
		for (int n = 0; n < NODES; n++) begin
			parent_of[n] = 0;
			for (int s = 0; s < 2; s++) begin
				kid_present[n][s] = 1'b0;
				kid_leaf[n][s]    = 1'b0;
				kid_val[n][s]     = '0;
			end
		end
		build_at    = 0;
		build_depth = 0;
		nodes_alloc = 1;
		walk_at     = 0;
	endfunction

	// Attach one symbol. The builder first climbs back past nodes whose two
	// children are both taken, then grows a left-first chain of new internal
	// nodes down to depth len-1, and hangs the leaf on the next free side.
	// A climb that would leave the root, or a chain that would overflow the
	// node store, drops the entry without touching anything.
	function automatic void tree_load(logic [6:0] sym, logic [6:0] len);
		int node;
		int d;
		int target;
		int need;
		int side;
		int n;
		node   = build_at;
		d      = build_depth;
		target = int'(len) - 1;
		while (kid_present[node][0] && kid_present[node][1]) begin
			if (node == 0)
				return;
			node = parent_of[node];
			d--;
		end
		need = (target > d) ? target - d : 0;
		if (nodes_alloc + need > NODES)
			return;
		for (int k = 0; k < need; k++) begin
			n = nodes_alloc;
			nodes_alloc++;
			side = kid_present[node][0] ? 1 : 0;
			kid_present[n][0] = 1'b0;
			kid_present[n][1] = 1'b0;
			parent_of[n] = node;
			kid_present[node][side] = 1'b1;
			kid_leaf[node][side]    = 1'b0;
			kid_val[node][side]     = n[6:0];
			node = n;
			d++;
		end
		side = kid_present[node][0] ? 1 : 0;
		kid_present[node][side] = 1'b1;
		kid_leaf[node][side]    = 1'b1;
		kid_val[node][side]     = sym;
		build_at    = node;
		build_depth = d;
	endfunction

	// Walk the tree one bit at a time, bit 0 first. Leaves and missing
	// children both emit a result and send the walk back to the root; the
	// final result of the byte carries the last flag.
	function automatic void tree_walk(logic [7:0] bits, logic [3:0] cnt, bit keep);
		int                steps;
		int                dir;
		pctd_pkg::result_t r;
		pctd_pkg::result_t batch[$];
		steps = (cnt > BYTE_BITS) ? BYTE_BITS : int'(cnt);
		for (int i = 0; i < steps; i++) begin
			dir = bits[i];
			r   = '0;
			if (!kid_present[walk_at][dir]) begin
				r.bad_code = 1'b1;
				batch = {batch, r};
				walk_at = 0;
			end else if (kid_leaf[walk_at][dir]) begin
				r.symbol_res = kid_val[walk_at][dir];
				batch = {batch, r};
				walk_at = 0;
			end else begin
				walk_at = int'(kid_val[walk_at][dir]);
			end
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		if (keep)
			owed_symbols = {owed_symbols, batch};
	endfunction

	// Update the tree for one accepted transaction. With keep low only the
	// state moves; the caller then supplies the results itself.
	function automatic void tree_apply(pctd_pkg::item_t it, bit keep);
		case (it.op)
			pctd_pkg::OP_CLEAR: tree_clear();
			pctd_pkg::OP_LOAD:  tree_load(it.symbol, it.code_length);
			pctd_pkg::OP_DATA:  tree_walk(it.data_byte, it.bit_count, keep);
			default:  ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Result checker. The receiver cannot stall, so every strobe is compared
	// against the front of the queue on the edge that ends its cycle.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		pctd_pkg::result_t want;
		if (arst_n && result_valid) begin
			results_seen++;
			if (result.bad_code)
				bad_seen++;
			if (owed_symbols.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result: expected none, actual sym=%0d last=%0b bad=%0b",
					$time, result.symbol_res, result.last, result.bad_code);
			end else begin
				want = owed_symbols.pop_front();
				if (result.symbol_res !== want.symbol_res) begin
					mismatches++;
					$display("%0t: symbol_res mismatch: expected %0d, actual %0d",
						$time, want.symbol_res, result.symbol_res);
				end
				if (result.last !== want.last) begin
					mismatches++;
					$display("%0t: last mismatch: expected %0b, actual %0b",
						$time, want.last, result.last);
				end
				if (result.bad_code !== want.bad_code) begin
					mismatches++;
					$display("%0t: bad_code mismatch: expected %0b, actual %0b",
						$time, want.bad_code, result.bad_code);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers. Every call starts and ends on a falling edge, so all
	// inputs change half a period away from the sampling edge.
	// ------------------------------------------------------------------------
	function automatic pctd_pkg::item_t make_item(logic [1:0] op, logic [6:0] sym,
		logic [6:0] len, logic [7:0] bits, logic [3:0] cnt);
		pctd_pkg::item_t it;
		it.op          = op;
		it.symbol      = sym;
		it.code_length = len;
		it.data_byte   = bits;
		it.bit_count   = cnt;
		return it;
	endfunction

	function automatic pctd_pkg::item_t noise_item();
		logic [31:0] raw;
		raw = $urandom;
		return pctd_pkg::item_t'(raw[$bits(pctd_pkg::item_t)-1:0]);
	endfunction

	// Present one transaction and hold it until the decoder takes it. The
	// prediction is made on the accepting edge; with keep low the caller
	// pushes hand-typed results instead.
	task automatic send(pctd_pkg::item_t it, bit keep);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		tree_apply(it, keep);
		if (it.op != OP_UNUSED)
			items_sent++;
		if (it.op == pctd_pkg::OP_LOAD)
			loads_sent++;
		if (it.op == pctd_pkg::OP_DATA)
			bytes_sent++;
		@(negedge clk);
	endtask

	// Stop sending and let the decoder run dry: nothing owed and not busy.
	task automatic quiesce();
		start <= 1'b0;
		do @(posedge clk); while (busy || owed_symbols.size() != 0);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Directed table. Rows whose outcome is obvious carry their results; the
	// rest are predicted from the behavioral tree.
	// ------------------------------------------------------------------------
	typedef struct {
		pctd_pkg::item_t   it;
		int                n_typed;
		pctd_pkg::result_t typed[2];
	} dir_row_t;

	dir_row_t steps_tbl[$];

	function automatic void add_row(pctd_pkg::item_t it, int n_typed,
		pctd_pkg::result_t a = '0, pctd_pkg::result_t b = '0);
		dir_row_t r;
		r.it       = it;
		r.n_typed  = n_typed;
		r.typed[0] = a;
		r.typed[1] = b;
		steps_tbl = {steps_tbl, r};
	endfunction

	function automatic pctd_pkg::result_t res(logic [6:0] sym, logic last, logic bad);
		pctd_pkg::result_t r;
		r.symbol_res = sym;
		r.last       = last;
		r.bad_code   = bad;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Random well-formed code: start from a two-leaf tree and split leaves in
	// place, which keeps the list in left-first order so the builder lays it
	// out exactly. Sometimes one leaf is dropped to leave a hole.
	// ------------------------------------------------------------------------
	task automatic send_code_run();
		int              depths[$];
		int              i;
		int              d;
		pctd_pkg::item_t it;
		depths = {1, 1};
		repeat ($urandom_range(0, 14)) begin
			i = $urandom_range(0, depths.size() - 1);
			d = depths[i];
			if (d < BYTE_BITS) begin
				depths[i] = d + 1;
				depths.insert(i + 1, d + 1);
			end
		end
		if ($urandom_range(3) == 0)
			depths.delete($urandom_range(0, depths.size() - 1));
		if ($urandom_range(99) < 90) begin
			it    = noise_item();
			it.op = pctd_pkg::OP_CLEAR;
			send(it, 1'b1);
		end
		foreach (depths[j]) begin
			it             = noise_item();
			it.op          = pctd_pkg::OP_LOAD;
			it.code_length = depths[j][6:0];
			send(it, 1'b1);
		end
		repeat ($urandom_range(3, 10)) begin
			it    = noise_item();
			it.op = pctd_pkg::OP_DATA;
			if ($urandom_range(99) < 80)
				it.bit_count = 4'd8;
			send(it, 1'b1);
		end
		// A few stray transactions: any opcode, any field values.
		if ($urandom_range(99) < 20)
			repeat ($urandom_range(1, 4))
				send(noise_item(), 1'b1);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		int base;
		mismatches   = 0;
		results_seen = 0;
		bad_seen     = 0;
		items_sent   = 0;
		loads_sent   = 0;
		bytes_sent   = 0;
		idle_pct     = 0;
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		tree_clear();

		// Empty tree: first bit hits a missing child.
		add_row(make_item(pctd_pkg::OP_DATA, 7'd0, 7'd0, 8'h00, 4'd1), 1,
			res(7'd0, 1'b1, 1'b1));
		// Zero bit count consumes nothing.
		add_row(make_item(pctd_pkg::OP_DATA, 7'h7F, 7'h7F, 8'hFF, 4'd0), 0);
		// Unused opcode is ignored.
		add_row(make_item(OP_UNUSED, 7'h7F, 7'h7F, 8'hFF, 4'hF), 0);
		// Two one-bit codes; symbol zero must still decode as a leaf.
		add_row(make_item(pctd_pkg::OP_LOAD, 7'd0, 7'd1, 8'h00, 4'd0), 0);
		add_row(make_item(pctd_pkg::OP_LOAD, 7'h7F, 7'd1, 8'hFF, 4'hF), 0);
		// Tree already full at the root: this entry is dropped.
		add_row(make_item(pctd_pkg::OP_LOAD, 7'd5, 7'd2, 8'h00, 4'd0), 0);
		add_row(make_item(pctd_pkg::OP_DATA, 7'd0, 7'd0, 8'b10, 4'd2), 2,
			res(7'd0, 1'b0, 1'b0), res(7'h7F, 1'b1, 1'b0));
		// Bit count above eight is clamped.
		add_row(make_item(pctd_pkg::OP_DATA, 7'd0, 7'd0, 8'hFF, 4'hF), FROM_TREE);
		add_row(make_item(pctd_pkg::OP_DATA, 7'd0, 7'd0, 8'hA5, 4'd9), FROM_TREE);
		add_row(make_item(pctd_pkg::OP_CLEAR, 7'h7F, 7'h7F, 8'hFF, 4'hF), 0);
		// Deepest codes: a long left chain that nearly fills the node store,
		// then entries beside it, until one no longer fits.
		add_row(make_item(pctd_pkg::OP_LOAD, 7'd9, 7'h7F, 8'h00, 4'd0), 0);
		add_row(make_item(pctd_pkg::OP_LOAD, 7'd10, 7'h7F, 8'h00, 4'd0), 0);
		add_row(make_item(pctd_pkg::OP_LOAD, 7'd11, 7'h7F, 8'h00, 4'd0), 0);
		add_row(make_item(pctd_pkg::OP_LOAD, 7'd12, 7'h7F, 8'h00, 4'd0), 0);
		add_row(make_item(pctd_pkg::OP_LOAD, 7'd13, 7'h7F, 8'h00, 4'd0), 0);
		// Zero length lands at the node reached after the climb.
		add_row(make_item(pctd_pkg::OP_LOAD, 7'd3, 7'd0, 8'h00, 4'd0), 0);
		add_row(make_item(pctd_pkg::OP_DATA, 7'd0, 7'd0, 8'hFF, 4'd8), FROM_TREE);
		add_row(make_item(pctd_pkg::OP_DATA, 7'd0, 7'd0, 8'h00, 4'd8), FROM_TREE);
		add_row(make_item(pctd_pkg::OP_CLEAR, 7'd0, 7'd0, 8'h00, 4'd0), 0);
		// Length shorter than the current depth attaches right where the
		// builder stands.
		add_row(make_item(pctd_pkg::OP_LOAD, 7'd1, 7'd3, 8'h00, 4'd0), 0);
		add_row(make_item(pctd_pkg::OP_DATA, 7'd0, 7'd0, 8'h00, 4'd1), FROM_TREE);
		add_row(make_item(pctd_pkg::OP_LOAD, 7'd2, 7'd1, 8'h00, 4'd0), 0);
		// The walk resumes where the earlier byte left it.
		add_row(make_item(pctd_pkg::OP_DATA, 7'd0, 7'd0, 8'h02, 4'd3), FROM_TREE);
		add_row(make_item(pctd_pkg::OP_DATA, 7'd0, 7'd0, 8'h55, 4'd8), FROM_TREE);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (steps_tbl[k]) begin
			if (steps_tbl[k].n_typed == FROM_TREE) begin
				send(steps_tbl[k].it, 1'b1);
			end else begin
				send(steps_tbl[k].it, 1'b0);
				for (int j = 0; j < steps_tbl[k].n_typed; j++)
					owed_symbols = {owed_symbols, steps_tbl[k].typed[j]};
			end
		end
		quiesce();

		// Random part in three phases of sender idling, with the pipe run dry
		// between phases and now and then within one.
		base = items_sent;
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 28 : (phase == 1) ? 67 : 0;
			while (items_sent - base < (RAND_ITEMS * (phase + 1)) / 3) begin
				send_code_run();
				if ($urandom_range(9) == 0)
					quiesce();
			end
			quiesce();
		end

		repeat (16) @(posedge clk);
		if (owed_symbols.size() != 0) begin
			mismatches++;
			$display("%0t: %0d expected results never arrived", $time, owed_symbols.size());
		end
		$display("Sent %0d transactions (%0d loads, %0d data bytes) under three idling mixes.",
			items_sent, loads_sent, bytes_sent);
		$display("Checked %0d decoded results, %0d of them bad codes.", results_seen, bad_seen);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		#4000000;
		$display("%0t: timeout", $time);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
